### rtl/core/eqrs_pkg.sv
// Package: shared types, constants and register map for the QRS beat-rate detector.
`default_nettype none
package eqrs_pkg;
  localparam int WindowDepth = 32;
  localparam int RateDepth = 8;
  localparam int WinIdxW = $clog2(WindowDepth);
  localparam int RateIdxW = $clog2(RateDepth);
  localparam logic [8:0] BaselineWeight = 9'd328;
  localparam logic [15:0] BpmNumerator = 16'd60000;
  localparam int AddrW = 6;

  localparam logic [AddrW-1:0] RegLpAlpha = 6'h00;
  localparam logic [AddrW-1:0] RegThreshold = 6'h08;
  localparam logic [AddrW-1:0] RegRefractory = 6'h10;
  localparam logic [AddrW-1:0] RegMinInterval = 6'h18;
  localparam logic [AddrW-1:0] RegMaxInterval = 6'h20;

  typedef struct packed {
    logic lead_off_plus;
    logic lead_off_minus;
    logic signed [15:0] raw_sample;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] filtered_value;
    logic [33:0] integrated_energy;
    logic [9:0] average_bpm;
    logic beat_active;
    logic leads_detached;
  } out_item_t;

  typedef struct packed {
    logic [15:0] lp_alpha;
    logic [33:0] beat_threshold;
    logic [15:0] refractory_ms;
    logic [10:0] min_interval_ms;
    logic [15:0] max_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic detach;
    logic lp_mul;
    logic lp_add;
    logic bl_mul;
    logic bl_add;
    logic slope;
    logic square;
    logic win_read;
    logic win_update;
    logic decide;
    logic div_start;
    logic div_step;
    logic rate_read;
    logic rate_update;
    logic mean;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic detached;
    logic rate_wanted;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

### rtl/core/eqrs_ctrl.sv
// Controller: sequences one sample through the datapath.
`default_nettype none
module eqrs_ctrl
  import eqrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  sts_t      sts,
  output logic      busy,
  output cmd_t      cmd
);
  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_LPM   = 15'b000000000000010,
    S_LPA   = 15'b000000000000100,
    S_BLM   = 15'b000000000001000,
    S_BLA   = 15'b000000000010000,
    S_SLOPE = 15'b000000000100000,
    S_SQ    = 15'b000000001000000,
    S_WRD   = 15'b000000010000000,
    S_WUP   = 15'b000000100000000,
    S_DEC   = 15'b000001000000000,
    S_DIV   = 15'b000010000000000,
    S_RRD   = 15'b000100000000000,
    S_RUP   = 15'b001000000000000,
    S_MEAN  = 15'b010000000000000,
    S_PUB   = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_LPM;
        end
      end
      S_LPM: begin
        if (sts.detached) begin
          cmd.detach = 1'b1;
          state_next = S_PUB;
        end else begin
          cmd.lp_mul = 1'b1;
          state_next = S_LPA;
        end
      end
      S_LPA: begin cmd.lp_add = 1'b1; state_next = S_BLM; end
      S_BLM: begin cmd.bl_mul = 1'b1; state_next = S_BLA; end
      S_BLA: begin cmd.bl_add = 1'b1; state_next = S_SLOPE; end
      S_SLOPE: begin cmd.slope = 1'b1; state_next = S_SQ; end
      S_SQ: begin cmd.square = 1'b1; cmd.win_read = 1'b1; state_next = S_WRD; end
      S_WRD: begin cmd.win_update = 1'b1; state_next = S_WUP; end
      S_WUP: begin cmd.decide = 1'b1; state_next = S_DEC; end
      S_DEC: begin
        if (sts.rate_wanted) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_PUB;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.rate_read = 1'b1;
          state_next = S_RRD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RRD: begin cmd.rate_update = 1'b1; state_next = S_RUP; end
      S_RUP: begin cmd.mean = 1'b1; state_next = S_MEAN; end
      S_MEAN: state_next = S_PUB;
      S_PUB: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/eqrs_dpath.sv
// Datapath: filters, energy window, beat decision, rate divider and rate ring.
`default_nettype none
module eqrs_dpath
  import eqrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      cmd,
  input  cfg_t      cfg,
  input  in_item_t  in_item,
  output sts_t      sts,
  output out_item_t result
);
  localparam int EnW = 35;
  localparam int SumW = EnW + WinIdxW;
  localparam int RtW = 10 + RateIdxW;

  in_item_t smp;
  logic signed [31:0] lp, bl;
  logic signed [24:0] prev;
  logic signed [47:0] prod;
  logic signed [25:0] slope;
  logic [EnW-1:0] sq, win_old;
  logic [SumW-1:0] esum;
  logic [WinIdxW-1:0] wslot;
  logic beat, awaiting;
  logic [31:0] last_ms;
  logic [31:0] elapsed;
  logic [31:0] divisor;
  logic rate_wanted;
  logic [EnW-1:0] ring_w [WindowDepth];
  logic [WindowDepth-1:0] wvalid;
  logic [9:0] ring_r [RateDepth];
  logic [RateDepth-1:0] rvalid;
  logic [9:0] rate_old;
  logic [RtW-1:0] rtotal;
  logic [RateIdxW-1:0] rslot;
  logic [9:0] mean;
  logic [15:0] quo;
  logic [31:0] rem;
  logic [4:0] dcnt;
  logic [9:0] bpm;

  logic signed [33:0] mterm;
  logic signed [16:0] mcoef;
  logic signed [47:0] rnd;
  logic signed [31:0] rnd_q;
  logic [33:0] energy;
  logic [24:0] mag;
  logic [32:0] rem_sh;

  always_comb begin
    if (cmd.lp_mul) begin
      mcoef = {1'b0, cfg.lp_alpha};
      mterm = {{10{smp.raw_sample[15]}}, smp.raw_sample, 8'd0} - 34'(lp);
    end else begin
      mcoef = {8'd0, BaselineWeight};
      mterm = 34'(lp) - 34'(bl);
    end
    rnd = prod + 48'sd32768;
    rnd_q = 32'(rnd >>> 16);
    energy = esum[WinIdxW+33:WinIdxW];
    mag = slope[25] ? 25'(-slope) : 25'(slope);
    rem_sh = {rem, 1'b0};
  end

  assign elapsed = smp.time_ms - last_ms;
  assign sts.detached = smp.lead_off_plus | smp.lead_off_minus;
  assign sts.rate_wanted = rate_wanted;
  assign sts.div_done = (dcnt == 5'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) smp <= in_item;
    if (cmd.lp_mul || cmd.bl_mul) prod <= 48'(mterm) * 48'(mcoef);
    if (cmd.slope) slope <= 26'(lp - bl) - 26'(prev);
    if (cmd.square) sq <= EnW'((50'(mag) * 50'(mag)) >> 16);
    if (cmd.win_read) win_old <= wvalid[wslot] ? ring_w[wslot] : '0;
    if (cmd.win_update) ring_w[wslot] <= sq;
    if (cmd.rate_read) rate_old <= rvalid[rslot] ? ring_r[rslot] : '0;
    if (cmd.rate_update) ring_r[rslot] <= bpm;
    if (cmd.publish) begin
      result.filtered_value <= prev[24:8];
      result.integrated_energy <= energy;
      result.average_bpm <= mean;
      result.beat_active <= beat;
      result.leads_detached <= sts.detached;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= '0; bl <= '0; prev <= '0; esum <= '0; wslot <= '0;
      wvalid <= '0; rvalid <= '0; beat <= 1'b0; awaiting <= 1'b1;
      last_ms <= '0; rtotal <= '0; rslot <= '0; mean <= '0;
      rate_wanted <= 1'b0; dcnt <= '0; quo <= '0; rem <= '0; bpm <= '0;
      divisor <= '0;
    end else begin
      if (cmd.detach) begin
        mean <= '0; beat <= 1'b0; awaiting <= 1'b1;
      end
      if (cmd.lp_add) lp <= lp + rnd_q;
      if (cmd.bl_add) bl <= bl + rnd_q;
      if (cmd.slope) prev <= 25'(lp - bl);
      if (cmd.win_update) begin
        esum <= esum - SumW'(win_old) + SumW'(sq);
        wvalid[wslot] <= 1'b1;
        wslot <= WinIdxW'((32'(wslot) + 1) % WindowDepth);
      end
      if (cmd.decide) begin
        logic hit;
        hit = (energy > cfg.beat_threshold) && !beat && (elapsed > 32'(cfg.refractory_ms));
        rate_wanted <= hit && !awaiting && (elapsed > 32'(cfg.min_interval_ms))
                       && (elapsed < 32'(cfg.max_interval_ms)) && (elapsed != 0);
        divisor <= elapsed;
        if (hit) begin
          last_ms <= smp.time_ms;
          awaiting <= 1'b0;
        end
        if (37'(energy) * 37'd5 < 37'(cfg.beat_threshold) * 37'd2) beat <= 1'b0;
        else if (hit) beat <= 1'b1;
      end
      if (cmd.div_start) begin
        quo <= BpmNumerator; rem <= '0; dcnt <= 5'd16;
      end
      if (cmd.div_step) begin
        if ({rem_sh[32:1], quo[15]} >= {1'b0, divisor}) begin
          rem <= 32'({rem[31:0], quo[15]} - {1'b0, divisor});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[15]};
          quo <= {quo[14:0], 1'b0};
        end
        dcnt <= dcnt - 5'd1;
      end
      if (cmd.rate_read) bpm <= (quo > 16'd1023) ? 10'd1023 : quo[9:0];
      if (cmd.rate_update) begin
        rtotal <= rtotal - RtW'(rate_old) + RtW'(bpm);
        rvalid[rslot] <= 1'b1;
        rslot <= RateIdxW'((32'(rslot) + 1) % RateDepth);
      end
      if (cmd.mean) mean <= 10'(rtotal >> RateIdxW);
    end
  end
endmodule
`default_nettype wire

### rtl/core/eqrs_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module eqrs_regs
  import eqrs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output cfg_t                  cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lp_alpha <= 16'd16384;
      cfg.beat_threshold <= 34'd1000;
      cfg.refractory_ms <= 16'd400;
      cfg.min_interval_ms <= 11'd200;
      cfg.max_interval_ms <= 16'd2000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegLpAlpha: cfg.lp_alpha <= pwdata[15:0];
        RegThreshold: cfg.beat_threshold <= pwdata[33:0];
        RegRefractory: cfg.refractory_ms <= pwdata[15:0];
        RegMinInterval: cfg.min_interval_ms <= pwdata[10:0];
        RegMaxInterval: cfg.max_interval_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      RegLpAlpha: prdata = 64'(cfg.lp_alpha);
      RegThreshold: prdata = 64'(cfg.beat_threshold);
      RegRefractory: prdata = 64'(cfg.refractory_ms);
      RegMinInterval: prdata = 64'(cfg.min_interval_ms);
      RegMaxInterval: prdata = 64'(cfg.max_interval_ms);
      default: prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/ecg_qrs_beat_rate_detector.sv
// Top level: QRS beat and heart-rate detector.
`default_nettype none
// One sample in, one result out. A sample with a lead off skips the filters and goes straight
// to publish; a normal sample runs the filter, energy and decision steps, and, when a beat
// yields a rate, the one-bit-per-cycle divider that forms 60000 / interval and the rate ring.
// The result sits in an output register; the next sample is taken once the previous result has been placed there.
module ecg_qrs_beat_rate_detector
  import eqrs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);
  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire, out_free;

  assign pready = 1'b1;
  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  eqrs_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg);
  eqrs_ctrl u_ctrl (.clk, .rst, .in_fire, .out_free, .sts, .busy, .cmd);
  eqrs_dpath u_dpath (.clk, .rst, .cmd, .cfg, .in_item(in_data), .sts, .result(out_data));
endmodule
`default_nettype wire

### rtl/core/eqrs_checker.sv
// Port-level checker for the QRS detector, bound to the top level.
`default_nettype none
module eqrs_checker
  import eqrs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("stall");
  a_no_take_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("double take");
  a_detach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.leads_detached |-> out_data.average_bpm == 10'd0
    && !out_data.beat_active) else $error("detach");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 !out_valid || out_ready || !in_ready) else $error("flow");
endmodule

bind ecg_qrs_beat_rate_detector eqrs_checker u_chk (.clk, .rst, .in_valid, .in_ready,
  .out_valid, .out_ready, .out_data);
`default_nettype wire

### test/tb_ecg_qrs_beat_rate_detector.sv
// Testbench for the QRS beat-rate detector: directed table plus random ECG-like traffic.
`timescale 1ns / 100ps
module tb_ecg_qrs_beat_rate_detector
  import eqrs_pkg::*;
();

  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 60;
  localparam logic [AddrW-1:0] RegUnused = 6'h28;

  typedef struct {
    in_item_t stim;
    bit       typed;
    out_item_t result;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  ecg_qrs_beat_rate_detector uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cfg_t cfg;
  longint lp_lvl, bl_lvl, prev_filt;
  longint unsigned energy_win[WindowDepth];
  longint unsigned energy_total;
  int unsigned win_pos;
  bit beat_on, first_beat;
  logic [31:0] last_beat;
  int unsigned rate_hist[RateDepth];
  int unsigned rate_sum, rate_pos, bpm_mean;

  out_item_t pending_results[$];
  bit failed = 1'b0;
  bit apb_busy = 1'b0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic void detector_reset();
    cfg.lp_alpha = 16'd16384;
    cfg.beat_threshold = 34'd1000;
    cfg.refractory_ms = 16'd400;
    cfg.min_interval_ms = 11'd200;
    cfg.max_interval_ms = 16'd2000;
    lp_lvl = 0;
    bl_lvl = 0;
    prev_filt = 0;
    foreach (energy_win[i]) energy_win[i] = 0;
    energy_total = 0;
    win_pos = 0;
    beat_on = 1'b0;
    first_beat = 1'b1;
    last_beat = '0;
    foreach (rate_hist[i]) rate_hist[i] = 0;
    rate_sum = 0;
    rate_pos = 0;
    bpm_mean = 0;
  endfunction

  function automatic out_item_t detect_beat(in_item_t x);
    out_item_t y;
    bit detached;
    longint raw, slope, filt;
    longint unsigned mag, sq, energy, thr;
    logic [31:0] elapsed;
    int unsigned bpm;
    detached = x.lead_off_plus | x.lead_off_minus;
    thr = longint'(cfg.beat_threshold);
    if (detached) begin
      bpm_mean = 0;
      beat_on = 1'b0;
      first_beat = 1'b1;
    end else begin
      raw = longint'($signed(x.raw_sample));
      lp_lvl += (longint'(cfg.lp_alpha) * (raw * 256 - lp_lvl) + 32768) >>> 16;
      bl_lvl += (longint'(BaselineWeight) * (lp_lvl - bl_lvl) + 32768) >>> 16;
      filt = lp_lvl - bl_lvl;
      slope = filt - prev_filt;
      prev_filt = filt;
      mag = (slope < 0) ? -slope : slope;
      sq = (mag * mag) >> 16;
      energy_total = energy_total - energy_win[win_pos] + sq;
      energy_win[win_pos] = sq;
      win_pos = (win_pos + 1) % WindowDepth;
      energy = energy_total / WindowDepth;
      elapsed = x.time_ms - last_beat;
      if (energy > thr && !beat_on && elapsed > cfg.refractory_ms) begin
        if (!first_beat && elapsed > cfg.min_interval_ms &&
            elapsed < cfg.max_interval_ms && elapsed != 0) begin
          bpm = 60000 / elapsed;
          if (bpm > 1023) bpm = 1023;
          rate_sum = rate_sum - rate_hist[rate_pos] + bpm;
          rate_hist[rate_pos] = bpm;
          rate_pos = (rate_pos + 1) % RateDepth;
          bpm_mean = rate_sum / RateDepth;
        end
        last_beat = x.time_ms;
        first_beat = 1'b0;
        beat_on = 1'b1;
      end
      if (5 * energy < 2 * thr) beat_on = 1'b0;
    end
    y.filtered_value = 17'(prev_filt >>> 8);
    y.integrated_energy = 34'(energy_total / WindowDepth);
    y.average_bpm = 10'(bpm_mean);
    y.beat_active = beat_on;
    y.leads_detached = detached;
    return y;
  endfunction

  task automatic reg_write(logic [AddrW-1:0] addr, logic [63:0] value);
    apb_busy = 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      RegLpAlpha: cfg.lp_alpha = value[15:0];
      RegThreshold: cfg.beat_threshold = value[33:0];
      RegRefractory: cfg.refractory_ms = value[15:0];
      RegMinInterval: cfg.min_interval_ms = value[10:0];
      RegMaxInterval: cfg.max_interval_ms = value[15:0];
      default: ;
    endcase
    apb_busy = 1'b0;
  endtask

  task automatic configure(cfg_t c);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    reg_write(RegLpAlpha, 64'(c.lp_alpha));
    reg_write(RegThreshold, 64'(c.beat_threshold));
    reg_write(RegRefractory, 64'(c.refractory_ms));
    reg_write(RegMinInterval, 64'(c.min_interval_ms));
    reg_write(RegMaxInterval, 64'(c.max_interval_ms));
    reg_write(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic send_sample(in_item_t x, bit typed = 1'b0, out_item_t result = '0);
    out_item_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    predicted = detect_beat(x);
    pending_results.push_back(typed ? result : predicted);
  endtask

  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_count <= $urandom_range(50, 400);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no sample pending");
        failed = 1'b1;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("filtered_value", exp_r.filtered_value, out_data.filtered_value);
        check_field("integrated_energy", exp_r.integrated_energy,
                    out_data.integrated_energy);
        check_field("average_bpm", exp_r.average_bpm, out_data.average_bpm);
        check_field("beat_active", exp_r.beat_active, out_data.beat_active);
        check_field("leads_detached", exp_r.leads_detached, out_data.leads_detached);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || apb_busy) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  logic [31:0] clock_ms;
  logic [31:0] next_beat_ms;
  int spike_left;

  function automatic in_item_t ecg_sample();
    in_item_t x;
    int pick;
    clock_ms += ($urandom_range(0, 49) == 0) ? $urandom_range(5, 3000) : 4;
    if (clock_ms - next_beat_ms < 32'h8000_0000 && spike_left == 0) begin
      spike_left = $urandom_range(1, 4);
      next_beat_ms = clock_ms + $urandom_range(150, 1600);
    end
    pick = $urandom_range(0, 99);
    x.lead_off_plus = (pick < 3);
    x.lead_off_minus = (pick >= 3 && pick < 6);
    x.time_ms = clock_ms;
    if (pick >= 96) begin
      x.raw_sample = 16'($urandom);
    end else if (spike_left != 0) begin
      x.raw_sample = 16'($urandom_range(8000, 32767));
      if ($urandom_range(0, 1) != 0) x.raw_sample = -x.raw_sample;
      spike_left--;
    end else begin
      x.raw_sample = 16'($signed($urandom_range(0, 400)) - 200);
    end
    return x;
  endfunction

  function automatic in_item_t mk(bit p, bit m, logic [15:0] raw, logic [31:0] t);
    in_item_t x;
    x.lead_off_plus = p;
    x.lead_off_minus = m;
    x.raw_sample = raw;
    x.time_ms = t;
    return x;
  endfunction

  row_t directed[$];
  cfg_t phase_cfg[$];

  initial begin
    cfg_t c;
    detector_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back('{mk(1, 0, 16'h7FFF, 32'd0), 1, '{'0, '0, '0, 1'b0, 1'b1}});
    directed.push_back('{mk(0, 1, 16'h8000, 32'd4), 1, '{'0, '0, '0, 1'b0, 1'b1}});
    directed.push_back('{mk(1, 1, 16'hFFFF, 32'hFFFF_FFFF), 1, '{'0, '0, '0, 1'b0, 1'b1}});
    directed.push_back('{mk(0, 0, 16'h0000, 32'd8), 0, '0});
    directed.push_back('{mk(0, 0, 16'h7FFF, 32'd500), 0, '0});
    directed.push_back('{mk(0, 0, 16'h8000, 32'd504), 0, '0});
    directed.push_back('{mk(0, 0, 16'h7FFF, 32'd508), 0, '0});
    directed.push_back('{mk(0, 0, 16'h0000, 32'd512), 0, '0});
    directed.push_back('{mk(0, 0, 16'h7FFF, 32'd1300), 0, '0});
    directed.push_back('{mk(0, 0, 16'h8000, 32'd1304), 0, '0});
    directed.push_back('{mk(0, 0, 16'h0000, 32'd1800), 0, '0});
    directed.push_back('{mk(0, 0, 16'h7FFF, 32'd2100), 0, '0});
    directed.push_back('{mk(0, 0, 16'h8000, 32'd2104), 0, '0});
    directed.push_back('{mk(1, 0, 16'h1234, 32'd2200), 0, '0});
    directed.push_back('{mk(0, 0, 16'h7FFF, 32'hFFFF_FF00), 0, '0});
    directed.push_back('{mk(0, 0, 16'h8000, 32'h0000_0100), 0, '0});
    directed.push_back('{mk(0, 0, 16'h5555, 32'hAAAA_AAAA), 0, '0});
    directed.push_back('{mk(0, 0, 16'hAAAA, 32'h5555_5555), 0, '0});
    foreach (directed[i]) send_sample(directed[i].stim, directed[i].typed, directed[i].result);

    phase_cfg.push_back('{16'd16384, 34'd1000, 16'd400, 11'd200, 16'd2000});
    phase_cfg.push_back('{16'd65535, 34'd0, 16'd0, 11'd0, 16'd65535});
    phase_cfg.push_back('{16'd0, 34'h3_FFFF_FFFF, 16'd65535, 11'd2047, 16'd100});
    phase_cfg.push_back('{16'd20000, 34'd5000, 16'd250, 11'd100, 16'd2000});
    phase_cfg.push_back('{16'd65535, 34'd200, 16'd0, 11'd0, 16'd65535});
    phase_cfg.push_back('{16'd1, 34'd1, 16'd1, 11'd2000, 16'd65535});
    c.lp_alpha = 16'($urandom);
    c.beat_threshold = 34'($urandom_range(0, 300000));
    c.refractory_ms = 16'($urandom_range(0, 600));
    c.min_interval_ms = 11'($urandom_range(100, 2000));
    c.max_interval_ms = 16'($urandom_range(100, 65535));
    phase_cfg.push_back(c);

    clock_ms = 32'hFFFF_F000;
    next_beat_ms = clock_ms;
    spike_left = 0;
    foreach (phase_cfg[p]) begin
      configure(phase_cfg[p]);
      repeat (93) send_sample(ecg_sample());
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (!failed) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

### filelist.f
rtl/core/eqrs_pkg.sv
rtl/core/eqrs_ctrl.sv
rtl/core/eqrs_dpath.sv
rtl/core/eqrs_regs.sv
rtl/core/ecg_qrs_beat_rate_detector.sv
rtl/core/eqrs_checker.sv
test/tb_ecg_qrs_beat_rate_detector.sv
